>>> design/running_mean_and_second_moment_assert.svh
// ----------------------------------------------------------------------------
// running mean and second moment: assertion macros
// clocked, reset-qualified concurrent assertion wrappers
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_AND_SECOND_MOMENT_ASSERT_SVH
`define RUNNING_MEAN_AND_SECOND_MOMENT_ASSERT_SVH

// generic form with explicit clock and reset
`define RMSM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// usual form on the block clock and reset
`define RMSM_ASSERT(lbl, prop, msg) \
    `RMSM_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> design/rmsm_pkg.sv
// ----------------------------------------------------------------------------
// rmsm_pkg
// types, widths and helpers shared by the running mean / moment block
// ----------------------------------------------------------------------------
package rmsm_pkg;

    localparam int MAX_RESOURCES = 4;
    localparam int MOM_DEPTH     = (MAX_RESOURCES * (MAX_RESOURCES + 1)) / 2;
    localparam int RAM_DEPTH     = MAX_RESOURCES + MOM_DEPTH;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);
    localparam int RES_W         = 2;
    localparam int DEM_W         = 16;
    localparam int FRAC_W        = 16;
    localparam int MEAN_W        = 32;
    localparam int VAL_W         = 48;
    localparam int CNT_W         = 11;
    localparam int NRES_W        = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_W         = 11;
    localparam int NUM_W         = VAL_W + CNT_W + 1;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STEPS     = NUM_W / DIV_BITS;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_RESOURCES = 1'd1;

    localparam logic [CNT_W-1:0]  LIMIT_RESET = 11'd20;
    localparam logic [NRES_W-1:0] NRES_RESET  = 3'd4;

    typedef struct packed {
        logic [DEM_W-1:0] demand_0;
        logic [DEM_W-1:0] demand_1;
        logic [DEM_W-1:0] demand_2;
        logic [DEM_W-1:0] demand_3;
    } t_in_word;

    typedef struct packed {
        logic             is_mean;
        logic [RES_W-1:0] row;
        logic [RES_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_WRITE
    } t_state;

    // ram address of a moment entry, upper triangle packed row by row
    function automatic logic [RAM_AW-1:0] moment_addr(logic [RES_W-1:0] row,
                                                      logic [RES_W-1:0] col);
        int base;
        base = MAX_RESOURCES;
        for (int i = 0; i < MAX_RESOURCES; i++) begin
            if (i < int'(row)) begin
                base = base + (MAX_RESOURCES - i);
            end
        end
        return RAM_AW'(base + int'(col) - int'(row));
    endfunction

endpackage

>>> design/rmsm_ram.sv
// ----------------------------------------------------------------------------
// rmsm_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rmsm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rmsm_div.sv
// ----------------------------------------------------------------------------
// rmsm_div
// restoring divider, numerator by sample count, four quotient bits a cycle
// ----------------------------------------------------------------------------
module rmsm_div import rmsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_numer,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic [NUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [NUM_W-1:0]  n_num;
    logic [CNT_W-1:0]  n_rem;

    // numerator shifts out at the top, quotient bits fill in at the bottom
    always_comb begin
        logic [CNT_W:0] t;
        n_num = r_num;
        n_rem = r_rem;
        for (int j = 0; j < DIV_BITS; j++) begin
            t     = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t        = t - {1'b0, r_div};
                n_num[0] = 1'b1;
            end
            n_rem = t[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_numer;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

>>> design/running_mean_and_second_moment.sv
// ----------------------------------------------------------------------------
// running_mean_and_second_moment
// running mean per resource and running mean of pairwise products, capped
// sample count, state held in one ram and updated read-modify-write
// ----------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+----------------------------
//  input    | i_valid / o_ready / i_data       | t_in_word, four demands
//  output   | o_valid / i_ready / o_data       | t_out_word, one entry
//  config   | i_cfg_we / i_cfg_idx / i_cfg_data| count_limit, num_resources
//
//  each entry goes through ram read, multiply, divider load, 15 divider
//  steps (60-bit numerator at 4 bits a cycle), divider done and write-back
//  an input word gives n means plus n(n+1)/2 moments
//  a new word is taken once the last entry is written; it may wait on output
//  an output stall holds the write-back of the next entry
//  synchronous active-low reset clears count and control, ram needs no clear
// ----------------------------------------------------------------------------
module running_mean_and_second_moment import rmsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_word             i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_word            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_limit;
    logic [NRES_W-1:0]  r_nres;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_c;
    logic [CNT_W-1:0]   n_c;
    logic [RES_W-1:0]   r_nlast;
    logic [RES_W-1:0]   n_nlast;
    logic [DEM_W-1:0]   r_x [MAX_RESOURCES];
    logic               r_is_mean;
    logic [RES_W-1:0]   r_row;
    logic [RES_W-1:0]   r_col;
    logic [NUM_W-1:0]   r_numer;
    logic               r_out_valid;
    t_out_word          r_out;
    logic               in_fire;
    logic               out_free;
    logic               entry_last;
    logic [RAM_AW-1:0]  addr;
    logic [VAL_W-1:0]   ram_rdata;
    logic [VAL_W-1:0]   old_val;
    logic [VAL_W-1:0]   sample;
    logic [VAL_W+CNT_W-1:0] prod;
    logic [2*DEM_W-1:0] pair;
    logic               ram_we;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   quot;
    logic [VAL_W-1:0]   new_val;

    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // effective limit, count after this sample, and last resource index
    always_comb begin
        logic [CNT_W-1:0] lim;
        lim     = (r_limit == '0) ? CNT_W'(1) : r_limit;
        n_count = (r_count < lim) ? r_count + 1'b1 : r_count;
        n_c     = (n_count == '0) ? CNT_W'(1) : n_count;
        if (r_nres == '0) begin
            n_nlast = '0;
        end else if (r_nres > NRES_W'(MAX_RESOURCES)) begin
            n_nlast = RES_W'(MAX_RESOURCES - 1);
        end else begin
            n_nlast = RES_W'(r_nres - 1'b1);
        end
    end

    assign entry_last = !r_is_mean && (r_row == r_nlast) && (r_col == r_nlast);
    assign addr       = r_is_mean ? RAM_AW'(r_row) : moment_addr(r_row, r_col);

    // numerator old*(c-1) + sample
    assign old_val = r_is_mean ? {{(VAL_W-MEAN_W){1'b0}}, ram_rdata[MEAN_W-1:0]}
                               : ram_rdata;
    assign pair    = r_x[r_row] * r_x[r_col];
    assign sample  = r_is_mean
                   ? {{(VAL_W-DEM_W-FRAC_W){1'b0}}, r_x[r_row], {FRAC_W{1'b0}}}
                   : {pair, {FRAC_W{1'b0}}};
    assign prod    = old_val * (r_c - 1'b1);
    assign new_val = r_is_mean ? {{(VAL_W-MEAN_W){1'b0}}, quot[MEAN_W-1:0]}
                               : quot[VAL_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_READ;
            ST_READ:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_WRITE;
            ST_WRITE: begin
                if (out_free) n_state = entry_last ? ST_IDLE : ST_READ;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        div_start = (r_state == ST_START);
        ram_we    = (r_state == ST_WRITE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_nres      <= NRES_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_is_mean   <= 1'b1;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_COUNT_LIMIT:   r_limit <= i_cfg_data;
                    REG_NUM_RESOURCES: r_nres  <= i_cfg_data[NRES_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_count   <= n_count;
                r_is_mean <= 1'b1;
                r_row     <= '0;
                r_col     <= '0;
            end
            if (ram_we) begin
                r_out_valid <= 1'b1;
                // step to the next entry
                if (r_is_mean) begin
                    if (r_row == r_nlast) begin
                        r_is_mean <= 1'b0;
                        r_row     <= '0;
                        r_col     <= '0;
                    end else begin
                        r_row <= r_row + 1'b1;
                        r_col <= r_col + 1'b1;
                    end
                end else if (r_col != r_nlast) begin
                    r_col <= r_col + 1'b1;
                end else if (r_row != r_nlast) begin
                    r_row <= r_row + 1'b1;
                    r_col <= r_row + 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_c     <= n_c;
            r_nlast <= n_nlast;
            r_x[0]  <= i_data.demand_0;
            r_x[1]  <= i_data.demand_1;
            r_x[2]  <= i_data.demand_2;
            r_x[3]  <= i_data.demand_3;
        end
        if (r_state == ST_MUL) begin
            r_numer <= {1'b0, prod} + {{(NUM_W-VAL_W){1'b0}}, sample};
        end
        if (ram_we) begin
            r_out.is_mean <= r_is_mean;
            r_out.row     <= r_row;
            r_out.col     <= r_col;
            r_out.value   <= new_val;
            r_out.last    <= entry_last;
        end
    end

    rmsm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (new_val),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    rmsm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_numer   (r_numer),
        .i_divisor (r_c),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> design/rmsm_check.sv
// ----------------------------------------------------------------------------
// rmsm_check
// port-level checks on the running mean / moment block, bound to the top
// ----------------------------------------------------------------------------
`include "running_mean_and_second_moment_assert.svh"

module rmsm_check import rmsm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input t_in_word             i_data,
    input logic                 o_valid,
    input logic                 i_ready,
    input t_out_word            o_data,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0]     i_cfg_data
);

    `RMSM_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_data), "output word changed while stalled")
    `RMSM_ASSERT(a_busy_after_accept, i_valid && o_ready |=> !o_ready, "input taken again while busy")
    `RMSM_ASSERT(a_no_accept_mid_run, o_valid && !o_data.last |-> !o_ready, "input ready in the middle of a run")
    `RMSM_ASSERT(a_index_order, o_valid |-> (o_data.row == o_data.col) || (!o_data.is_mean && o_data.row < o_data.col), "entry indices out of triangle")

endmodule

bind running_mean_and_second_moment rmsm_check u_check (.*);
